[src/pfrc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfrc_pkg
// Shared types and constants for the synthesizer register word calculator.
// ----------------------------------------------------------------------------
package pfrc_pkg;

  localparam int FREQ_W = 16;
  localparam int WORD_W = 32;
  localparam int M_W    = 13;
  localparam int V_W    = 18;
  localparam int Q_W    = 9;
  localparam int INT_W  = 8;
  localparam int FRAC_W = 10;
  localparam int K_W    = 3;
  localparam int A_W    = 2;
  localparam int CFG_AW = 2;

  localparam logic [FREQ_W-1:0] FREQ_MIN  = 16'd350;
  localparam logic [FREQ_W-1:0] FREQ_MAX  = 16'd44000;
  localparam logic [18:0]       VCO_LOW   = 19'd2200;
  localparam logic [18:0]       VCO_HIGH  = 19'd4400;
  localparam logic [K_W-1:0]    MAX_K     = 3'd6;
  localparam logic [16:0]       RECIP_10  = 17'd52429;
  localparam logic [12:0]       RECIP_1000 = 13'd4194;
  localparam logic [9:0]        MOD_START = 10'd1000;
  localparam logic [7:0]        RECIP_5   = 8'd205;

  localparam logic [CFG_AW-1:0] REG_MOD_BASE = 2'd0;
  localparam logic [CFG_AW-1:0] REG_DIV_BASE = 2'd1;
  localparam logic [CFG_AW-1:0] REG_RF_OFF   = 2'd2;

  localparam logic [WORD_W-1:0] MOD_BASE_RST = 32'h0000_8001;
  localparam logic [WORD_W-1:0] DIV_BASE_RST = 32'h008C_803C;
  localparam logic [WORD_W-1:0] RF_OFF_RST   = 32'h00EC_801C;

  localparam logic [1:0] WORD_RF_OFF = 2'd0;
  localparam logic [1:0] WORD_R1     = 2'd1;
  localparam logic [1:0] WORD_R0     = 2'd2;
  localparam logic [1:0] WORD_R4     = 2'd3;

  typedef struct packed {
    logic [V_W-1:0] v;
    logic [K_W-1:0] k;
  } pfrc_vk_t;

  typedef struct packed {
    logic [INT_W-1:0]  int_part;
    logic [FRAC_W-1:0] frac;
    logic [K_W-1:0]    k;
  } pfrc_if_t;

  typedef struct packed {
    logic [INT_W-1:0]  int_part;
    logic [FRAC_W-1:0] frac;
    logic [FRAC_W-1:0] modv;
    logic [K_W-1:0]    k;
  } pfrc_res_t;

  typedef struct packed {
    logic [WORD_W-1:0] mod_base;
    logic [WORD_W-1:0] div_base;
    logic [WORD_W-1:0] rf_off;
  } pfrc_cfg_t;

endpackage

[src/pfrc_divsel.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfrc_divsel
// Clamp the frequency, pick the output divider exponent and scale to v.
// ----------------------------------------------------------------------------
module pfrc_divsel
  import pfrc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [FREQ_W-1:0] in_freq,
  output logic              out_valid,
  output pfrc_vk_t          out_data
);

  logic              v1_r;
  logic [FREQ_W-1:0] f1_r;
  logic [M_W-1:0]    m1_r;
  logic              v2_r;
  pfrc_vk_t          d2_r;

  logic [FREQ_W-1:0] f_c;
  logic [32:0]       m_prod;
  logic [K_W-1:0]    k_nxt;
  logic [23:0]       v_wide;

  always_comb begin
    f_c = in_freq;
    if (in_freq < FREQ_MIN) f_c = FREQ_MIN;
    if (in_freq > FREQ_MAX) f_c = FREQ_MAX;
    m_prod = 33'(f_c) * 33'(RECIP_10);
  end

  always_comb begin
    logic [18:0] p;
    k_nxt = MAX_K;
    for (int j = 6; j >= 0; j--) begin
      p = 19'(m1_r) << j;
      if (p >= VCO_LOW && p <= VCO_HIGH) k_nxt = K_W'(j);
    end
    v_wide = 24'(f1_r) << ({1'b0, k_nxt} + 4'd2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_r   <= f_c;
      m1_r   <= m_prod[31:19];
      d2_r.v <= v_wide[V_W-1:0];
      d2_r.k <= k_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_data  = d2_r;

endmodule

[src/pfrc_split.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfrc_split
// Split v into INT and FRAC by a reciprocal multiply and one correction.
// ----------------------------------------------------------------------------
module pfrc_split
  import pfrc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  logic     in_valid,
  input  pfrc_vk_t in_data,
  output logic     out_valid,
  output pfrc_if_t out_data
);

  logic           v3_r;
  pfrc_vk_t       d3_r;
  logic [Q_W-1:0] q3_r;
  logic           v4_r;
  pfrc_if_t       d4_r;

  logic [30:0] q_prod;
  logic [18:0] r_full;
  logic [Q_W-1:0] q_fix;
  logic [10:0] r_fix;

  always_comb begin
    q_prod = 31'(in_data.v) * 31'(RECIP_1000);
    r_full = 19'(d3_r.v) - 19'(q3_r) * 19'(MOD_START);
    q_fix  = q3_r;
    r_fix  = r_full[10:0];
    if (r_full[10:0] >= 11'(MOD_START)) begin
      q_fix = q3_r + 1'b1;
      r_fix = r_full[10:0] - 11'(MOD_START);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v3_r <= in_valid;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d3_r          <= in_data;
      q3_r          <= q_prod[30:22];
      d4_r.int_part <= q_fix[INT_W-1:0];
      d4_r.frac     <= r_fix[FRAC_W-1:0];
      d4_r.k        <= d3_r.k;
    end
  end

  assign out_valid = v4_r;
  assign out_data  = d4_r;

endmodule

[src/pfrc_reduce.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfrc_reduce
// Reduce FRAC/MOD by common factors of five, then of two.
// ----------------------------------------------------------------------------
module pfrc_reduce
  import pfrc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      in_valid,
  input  pfrc_if_t  in_data,
  output logic      out_valid,
  output pfrc_res_t out_data
);

  localparam int STEPS = 3;

  logic              sv_r [STEPS];
  pfrc_if_t          sd_r [STEPS];
  logic [A_W-1:0]    sa_r [STEPS];
  pfrc_if_t          sd_in [STEPS];
  logic [A_W-1:0]    sa_in [STEPS];
  pfrc_if_t          sd_nxt [STEPS];
  logic [A_W-1:0]    sa_nxt [STEPS];
  logic              v8_r;
  pfrc_res_t         d8_r;

  logic [1:0]        tz;
  logic [FRAC_W-1:0] mod5;

  always_comb begin
    logic [17:0] prod;
    logic [7:0]  q5;
    for (int s = 0; s < STEPS; s++) begin
      sd_in[s] = (s == 0) ? in_data : sd_r[(s == 0) ? 0 : s - 1];
      sa_in[s] = (s == 0) ? '0 : sa_r[(s == 0) ? 0 : s - 1];
      prod      = 18'(sd_in[s].frac) * 18'(RECIP_5);
      q5        = prod[17:10];
      sd_nxt[s] = sd_in[s];
      sa_nxt[s] = sa_in[s];
      if ((10'(q5) * 10'd5) == sd_in[s].frac) begin
        sd_nxt[s].frac = 10'(q5);
        sa_nxt[s]      = sa_in[s] + 1'b1;
      end
    end
  end

  always_comb begin
    logic [FRAC_W-1:0] fr;
    fr = sd_r[STEPS-1].frac;
    if (fr[0])      tz = 2'd0;
    else if (fr[1]) tz = 2'd1;
    else if (fr[2]) tz = 2'd2;
    else            tz = 2'd3;
    unique case (sa_r[STEPS-1])
      2'd0:    mod5 = 10'd1000;
      2'd1:    mod5 = 10'd200;
      2'd2:    mod5 = 10'd40;
      default: mod5 = 10'd8;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < STEPS; s++) sv_r[s] <= 1'b0;
      v8_r <= 1'b0;
    end else if (en) begin
      sv_r[0] <= in_valid;
      for (int s = 1; s < STEPS; s++) sv_r[s] <= sv_r[s-1];
      v8_r <= sv_r[STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < STEPS; s++) begin
        sd_r[s] <= sd_nxt[s];
        sa_r[s] <= sa_nxt[s];
      end
      d8_r.int_part <= sd_r[STEPS-1].int_part;
      d8_r.frac     <= sd_r[STEPS-1].frac >> tz;
      d8_r.modv     <= mod5 >> tz;
      d8_r.k        <= sd_r[STEPS-1].k;
    end
  end

  assign out_valid = v8_r;
  assign out_data  = d8_r;

endmodule

[src/pfrc_serdes.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfrc_serdes
// Hold one result and send its four register words, one per transfer.
// ----------------------------------------------------------------------------
module pfrc_serdes
  import pfrc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  pfrc_cfg_t         cfg,
  input  logic              in_valid,
  input  pfrc_res_t         in_data,
  output logic              take,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [WORD_W-1:0] out_tdata,
  output logic              out_tlast
);

  logic      busy_r;
  logic [1:0] idx_r;
  pfrc_res_t res_r;
  logic      fire;

  assign fire = busy_r && out_tready;
  assign take = !busy_r || (fire && idx_r == WORD_R4);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= WORD_RF_OFF;
    end else if (take) begin
      busy_r <= in_valid;
      idx_r  <= WORD_RF_OFF;
    end else if (fire) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_valid) res_r <= in_data;
  end

  always_comb begin
    unique case (idx_r)
      WORD_RF_OFF: out_tdata = cfg.rf_off;
      WORD_R1:     out_tdata = cfg.mod_base + (32'(res_r.modv) << 3);
      WORD_R0:     out_tdata = (32'(res_r.int_part) << 15) + (32'(res_r.frac) << 3);
      default:     out_tdata = cfg.div_base + (32'(res_r.k) << 20);
    endcase
  end

  assign out_tvalid = busy_r;
  assign out_tlast  = (idx_r == WORD_R4);

`ifndef SYNTH
  a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && out_tlast) |=> (idx_r == WORD_RF_OFF))
    else $error("word index did not wrap after last word");

  a_idx_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !out_tlast) |=> (idx_r == $past(idx_r) + 2'd1) && busy_r)
    else $error("word index did not advance");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !out_tready) |=> (busy_r && $stable(idx_r)))
    else $error("result dropped while stalled");
`endif

endmodule

[src/pll_frequency_register_calc.sv]
`timescale 1ns / 1ps
// A request's first word is offered once it has left the 8-stage pipeline.
// The pipeline takes an item every cycle unless the four-word output sequencer
//   stalls it, as it does while a request's words are still being sent.
// Reset: synchronous active-low rst_n clears all valid bits and the sequencer
//   and loads the configuration registers with their default words.
// ----------------------------------------------------------------------------
// pll_frequency_register_calc
// Convert a target frequency into the four synthesizer register words.
// ----------------------------------------------------------------------------
module pll_frequency_register_calc
  import pfrc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [15:0]       in_tdata,   // [15:0] freq_tenths_mhz
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,  // [31:0] reg_word
  output logic              out_tlast,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [WORD_W-1:0] cfg_wdata
);

  pfrc_cfg_t cfg_r;
  logic      en;
  logic      take;
  logic      ds_valid;
  pfrc_vk_t  ds_data;
  logic      sp_valid;
  pfrc_if_t  sp_data;
  logic      rd_valid;
  pfrc_res_t rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mod_base <= MOD_BASE_RST;
      cfg_r.div_base <= DIV_BASE_RST;
      cfg_r.rf_off   <= RF_OFF_RST;
    end else if (cfg_we) begin
      if (cfg_addr == REG_MOD_BASE) cfg_r.mod_base <= cfg_wdata;
      if (cfg_addr == REG_DIV_BASE) cfg_r.div_base <= cfg_wdata;
      if (cfg_addr == REG_RF_OFF)   cfg_r.rf_off   <= cfg_wdata;
    end
  end

  assign en        = !rd_valid || take;
  assign in_tready = en;

  pfrc_divsel u_divsel (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .in_freq   (in_tdata),
    .out_valid (ds_valid),
    .out_data  (ds_data)
  );

  pfrc_split u_split (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (ds_valid),
    .in_data   (ds_data),
    .out_valid (sp_valid),
    .out_data  (sp_data)
  );

  pfrc_reduce u_reduce (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sp_valid),
    .in_data   (sp_data),
    .out_valid (rd_valid),
    .out_data  (rd_data)
  );

  pfrc_serdes u_serdes (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (rd_valid),
    .in_data    (rd_data),
    .take       (take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
